### rtl/lkdq_pkg.sv
package lkdq_pkg;

    localparam int POOL_DEPTH_DEF = 64;
    localparam int LEN_W          = 7;

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_POP_BACK   = 3'd1;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_INS_AFTER  = 3'd4;
    localparam logic [2:0] OP_INS_BEFORE = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_ALLOC,
        S_LINK,
        S_POP_FIX,
        S_RESP
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_PUSH_SETUP,
        CMD_POP_RD,
        CMD_POP_FIX,
        CMD_SEARCH_INIT,
        CMD_SEARCH_RD,
        CMD_SEARCH_HIT,
        CMD_SEARCH_NEXT,
        CMD_ALLOC,
        CMD_LINK,
        CMD_FAIL,
        CMD_LOAD_OUT
    } t_cmd;

    typedef struct packed {
        t_cmd    cmd;
        t_status st;
    } t_dp_ctrl;

    typedef struct packed {
        logic [2:0] op;
        logic       end_nil;
        logic       p_nil;
        logic       match;
        logic       full;
        logic       out_free;
    } t_dp_stat;

endpackage

### rtl/lkdq_ctrl.sv
module lkdq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  lkdq_pkg::t_dp_stat i_stat,
    output lkdq_pkg::t_dp_ctrl o_ctrl
);

    lkdq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkdq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        o_ctrl.cmd  = lkdq_pkg::CMD_NONE;
        o_ctrl.st   = lkdq_pkg::ST_OK;
        case (r_state)
            lkdq_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.cmd = lkdq_pkg::CMD_CAPTURE;
                    n_state    = lkdq_pkg::S_DECODE;
                end
            end
            lkdq_pkg::S_DECODE: begin
                case (i_stat.op)
                    lkdq_pkg::OP_PUSH_BACK, lkdq_pkg::OP_PUSH_FRONT: begin
                        o_ctrl.cmd = lkdq_pkg::CMD_PUSH_SETUP;
                        n_state    = lkdq_pkg::S_ALLOC;
                    end
                    lkdq_pkg::OP_POP_BACK, lkdq_pkg::OP_POP_FRONT: begin
                        if (i_stat.end_nil) begin
                            o_ctrl.cmd = lkdq_pkg::CMD_FAIL;
                            o_ctrl.st  = lkdq_pkg::ST_EMPTY;
                            n_state    = lkdq_pkg::S_RESP;
                        end else begin
                            o_ctrl.cmd = lkdq_pkg::CMD_POP_RD;
                            n_state    = lkdq_pkg::S_POP_FIX;
                        end
                    end
                    lkdq_pkg::OP_INS_AFTER, lkdq_pkg::OP_INS_BEFORE: begin
                        o_ctrl.cmd = lkdq_pkg::CMD_SEARCH_INIT;
                        n_state    = lkdq_pkg::S_SEARCH_RD;
                    end
                    default: begin
                        n_state = lkdq_pkg::S_RESP;
                    end
                endcase
            end
            lkdq_pkg::S_SEARCH_RD: begin
                if (i_stat.p_nil) begin
                    o_ctrl.cmd = lkdq_pkg::CMD_FAIL;
                    o_ctrl.st  = lkdq_pkg::ST_NOT_FOUND;
                    n_state    = lkdq_pkg::S_RESP;
                end else begin
                    o_ctrl.cmd = lkdq_pkg::CMD_SEARCH_RD;
                    n_state    = lkdq_pkg::S_SEARCH_CMP;
                end
            end
            lkdq_pkg::S_SEARCH_CMP: begin
                if (i_stat.match) begin
                    o_ctrl.cmd = lkdq_pkg::CMD_SEARCH_HIT;
                    n_state    = lkdq_pkg::S_ALLOC;
                end else begin
                    o_ctrl.cmd = lkdq_pkg::CMD_SEARCH_NEXT;
                    n_state    = lkdq_pkg::S_SEARCH_RD;
                end
            end
            lkdq_pkg::S_ALLOC: begin
                if (i_stat.full) begin
                    o_ctrl.cmd = lkdq_pkg::CMD_FAIL;
                    o_ctrl.st  = lkdq_pkg::ST_FULL;
                    n_state    = lkdq_pkg::S_RESP;
                end else begin
                    o_ctrl.cmd = lkdq_pkg::CMD_ALLOC;
                    n_state    = lkdq_pkg::S_LINK;
                end
            end
            lkdq_pkg::S_LINK: begin
                o_ctrl.cmd = lkdq_pkg::CMD_LINK;
                n_state    = lkdq_pkg::S_RESP;
            end
            lkdq_pkg::S_POP_FIX: begin
                o_ctrl.cmd = lkdq_pkg::CMD_POP_FIX;
                n_state    = lkdq_pkg::S_RESP;
            end
            lkdq_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    o_ctrl.cmd = lkdq_pkg::CMD_LOAD_OUT;
                    n_state    = lkdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lkdq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/lkdq_dp.sv
module lkdq_dp #(
    parameter int POOL_DEPTH = lkdq_pkg::POOL_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [2:0]                       i_operation,
    input  logic [7:0]                       i_new_value,
    input  logic [7:0]                       i_search_key,
    input  logic                             i_ready,
    output logic                             o_valid,
    output logic [7:0]                       o_removed_value,
    output logic [1:0]                       o_status,
    output logic [lkdq_pkg::LEN_W-1:0]       o_length,
    input  lkdq_pkg::t_dp_ctrl               i_ctrl,
    output lkdq_pkg::t_dp_stat               o_stat
);

    localparam int LW = $clog2(POOL_DEPTH + 1);
    localparam int IW = $clog2(POOL_DEPTH);
    localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

    // node pool
    logic [7:0]    value_mem [POOL_DEPTH];
    logic [LW-1:0] next_mem  [POOL_DEPTH];
    logic [LW-1:0] prev_mem  [POOL_DEPTH];

    logic [7:0]    r_val_rd;
    logic [LW-1:0] r_next_rd, r_prev_rd;

    logic [2:0]    r_op;
    logic [7:0]    r_val, r_key, r_removed;
    lkdq_pkg::t_status r_status;
    logic [LW-1:0] r_head, r_tail, r_free, r_fresh, r_count;
    logic [LW-1:0] r_a, r_b, r_n, r_p;
    logic          r_from_free;

    logic          r_o_valid;
    logic [7:0]    r_o_removed;
    logic [1:0]    r_o_status;
    logic [lkdq_pkg::LEN_W-1:0] r_o_length;

    logic          pop_back, free_ok;
    logic [LW-1:0] end_node, alloc_node;
    logic [LW+lkdq_pkg::LEN_W-1:0] count_ext;

    // read and write port controls
    logic [IW-1:0] val_ra, next_ra, prev_ra;
    logic          val_we, next_we, prev_we;
    logic [IW-1:0] val_wa, next_wa, prev_wa;
    logic [LW-1:0] next_wd, prev_wd;

    function automatic logic is_node(input logic [LW-1:0] x);
        return x < NIL;
    endfunction

    assign pop_back   = (r_op == lkdq_pkg::OP_POP_BACK);
    assign end_node   = pop_back ? r_tail : r_head;
    assign free_ok    = is_node(r_free);
    assign alloc_node = free_ok ? r_free : r_fresh;
    assign count_ext  = {{lkdq_pkg::LEN_W{1'b0}}, r_count};

    assign o_stat.op       = r_op;
    assign o_stat.end_nil  = !is_node(end_node);
    assign o_stat.p_nil    = !is_node(r_p);
    assign o_stat.match    = (r_val_rd == r_key);
    assign o_stat.full     = (r_count == NIL);
    assign o_stat.out_free = !r_o_valid || i_ready;

    always_comb begin
        val_ra  = r_p[IW-1:0];
        next_ra = r_p[IW-1:0];
        prev_ra = r_p[IW-1:0];
        val_we  = 1'b0;
        next_we = 1'b0;
        prev_we = 1'b0;
        val_wa  = alloc_node[IW-1:0];
        next_wa = alloc_node[IW-1:0];
        prev_wa = alloc_node[IW-1:0];
        next_wd = r_b;
        prev_wd = r_a;
        case (i_ctrl.cmd)
            lkdq_pkg::CMD_POP_RD: begin
                val_ra  = end_node[IW-1:0];
                next_ra = end_node[IW-1:0];
                prev_ra = end_node[IW-1:0];
                // retired node goes on top of the free chain
                next_we = 1'b1;
                next_wa = end_node[IW-1:0];
                next_wd = r_free;
            end
            lkdq_pkg::CMD_ALLOC: begin
                next_ra = r_free[IW-1:0];
                val_we  = 1'b1;
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            lkdq_pkg::CMD_LINK: begin
                next_we = is_node(r_a);
                next_wa = r_a[IW-1:0];
                next_wd = r_n;
                prev_we = is_node(r_b);
                prev_wa = r_b[IW-1:0];
                prev_wd = r_n;
            end
            lkdq_pkg::CMD_POP_FIX: begin
                next_we = pop_back && is_node(r_prev_rd);
                next_wa = r_prev_rd[IW-1:0];
                next_wd = NIL;
                prev_we = !pop_back && is_node(r_next_rd);
                prev_wa = r_next_rd[IW-1:0];
                prev_wd = NIL;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val_rd  <= value_mem[val_ra];
        r_next_rd <= next_mem[next_ra];
        r_prev_rd <= prev_mem[prev_ra];
        if (val_we) begin
            value_mem[val_wa] <= r_val;
        end
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            lkdq_pkg::CMD_CAPTURE: begin
                r_op      <= i_operation;
                r_val     <= i_new_value;
                r_key     <= i_search_key;
                r_removed <= 8'd0;
                r_status  <= lkdq_pkg::ST_OK;
            end
            lkdq_pkg::CMD_PUSH_SETUP: begin
                r_a <= (r_op == lkdq_pkg::OP_PUSH_BACK) ? r_tail : NIL;
                r_b <= (r_op == lkdq_pkg::OP_PUSH_BACK) ? NIL : r_head;
            end
            lkdq_pkg::CMD_SEARCH_INIT: r_p <= r_head;
            lkdq_pkg::CMD_SEARCH_NEXT: r_p <= r_next_rd;
            lkdq_pkg::CMD_SEARCH_HIT: begin
                r_a <= (r_op == lkdq_pkg::OP_INS_AFTER) ? r_p : r_prev_rd;
                r_b <= (r_op == lkdq_pkg::OP_INS_AFTER) ? r_next_rd : r_p;
            end
            lkdq_pkg::CMD_ALLOC: begin
                r_n         <= alloc_node;
                r_from_free <= free_ok;
            end
            lkdq_pkg::CMD_POP_FIX: r_removed <= r_val_rd;
            lkdq_pkg::CMD_FAIL:    r_status  <= i_ctrl.st;
            default: begin
            end
        endcase
        if (i_ctrl.cmd == lkdq_pkg::CMD_LOAD_OUT) begin
            r_o_removed <= r_removed;
            r_o_status  <= r_status;
            r_o_length  <= count_ext[lkdq_pkg::LEN_W-1:0];
        end
    end

    // list and pool control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= NIL;
            r_tail    <= NIL;
            r_free    <= NIL;
            r_fresh   <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            case (i_ctrl.cmd)
                lkdq_pkg::CMD_ALLOC: begin
                    // never-used nodes come from a fill counter
                    if (!free_ok) begin
                        r_fresh <= r_fresh + 1'b1;
                    end
                end
                lkdq_pkg::CMD_LINK: begin
                    if (r_from_free) begin
                        r_free <= r_next_rd;
                    end
                    if (!is_node(r_a)) begin
                        r_head <= r_n;
                    end
                    if (!is_node(r_b)) begin
                        r_tail <= r_n;
                    end
                    r_count <= r_count + 1'b1;
                end
                lkdq_pkg::CMD_POP_RD: begin
                    r_free  <= end_node;
                    r_count <= r_count - 1'b1;
                end
                lkdq_pkg::CMD_POP_FIX: begin
                    if (pop_back) begin
                        r_tail <= r_prev_rd;
                        if (!is_node(r_prev_rd)) begin
                            r_head <= NIL;
                        end
                    end else begin
                        r_head <= r_next_rd;
                        if (!is_node(r_next_rd)) begin
                            r_tail <= NIL;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (i_ctrl.cmd == lkdq_pkg::CMD_LOAD_OUT) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_removed_value = r_o_removed;
    assign o_status        = r_o_status;
    assign o_length        = r_o_length;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("entry count above pool depth");

    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.cmd == lkdq_pkg::CMD_CAPTURE) |->
        (is_node(r_head) == is_node(r_tail)) && (is_node(r_head) == (r_count != '0)))
        else $error("head, tail and count disagree");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.cmd == lkdq_pkg::CMD_ALLOC) |-> is_node(alloc_node))
        else $error("allocation outside the pool");

    a_load_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.cmd == lkdq_pkg::CMD_LOAD_OUT) |=> r_o_valid)
        else $error("result register not loaded");

endmodule

### rtl/linked_deque_with_insert_top.sv
// Doubly linked deque of bytes in a fixed node pool.
// Request channel: i_valid / o_ready with i_operation, i_new_value,
// i_search_key. One request is one operation: push back/front, pop
// back/front, or insert after/before the first node holding the key.
// Result channel: o_valid / i_ready with o_removed_value, o_status
// (ok, empty, full, not found) and o_length; one result per request.
// Requests are handled one at a time by the controller sequencer; each
// pool memory has one registered read and one write port per cycle.
// Steps from accept to result: push runs decode, alloc, link; pop runs
// decode with the end-node read, then pop fix; ignored codes go from
// decode straight to the result; insert first walks the key search, a
// registered read of value/next then a compare per node, then alloc and
// link. A new request is taken in the cycle after the result is loaded.
// Reset: list empty, free chain empty, fill counter at zero; never-used
// nodes are handed out by the fill counter, so no clearing pass is needed.
// A stalled receiver holds the result register; the next request is
// still accepted and processed and waits only to load its result.
module linked_deque_with_insert_top #(
    parameter int POOL_DEPTH = lkdq_pkg::POOL_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_operation,
    input  logic [7:0]                 i_new_value,
    input  logic [7:0]                 i_search_key,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_removed_value,
    output logic [1:0]                 o_status,
    output logic [lkdq_pkg::LEN_W-1:0] o_length
);

    lkdq_pkg::t_dp_ctrl ctrl;
    lkdq_pkg::t_dp_stat stat;

    lkdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    lkdq_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_operation     (i_operation),
        .i_new_value     (i_new_value),
        .i_search_key    (i_search_key),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_length        (o_length),
        .i_ctrl          (ctrl),
        .o_stat          (stat)
    );

endmodule
